// ----- rtl/lbps_pkg.sv -----
`timescale 1ns / 1ps

package lbps_pkg;

  localparam int unsigned SpanBitsDef = 10;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STEADY_ON = 2'd2;
  localparam logic [1:0] CMD_STEADY_OFF = 2'd3;

  localparam logic [3:0] NO_PATTERN = 4'd8;

  localparam logic [CfgIdxW-1:0] CFG_ACTIVE_LEVEL = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SHORT_SPAN = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LONG_SPAN = 2'd2;

  localparam logic [CfgDataW-1:0] SHORT_SPAN_RST = 10'd200;
  localparam logic [CfgDataW-1:0] LONG_SPAN_RST = 10'd800;

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] pattern_select;
  } req_t;

  typedef struct packed {
    logic       pin_level;
    logic       led_lit;
    logic       pattern_running;
    logic [2:0] step_index;
  } res_t;

  typedef struct packed {
    logic                active_level;
    logic [CfgDataW-1:0] short_span;
    logic [CfgDataW-1:0] long_span;
  } cfg_t;

  typedef struct packed {
    logic [3:0] length;
    logic [7:0] lit_bits;
    logic [7:0] long_bits;
  } rom_entry_t;

  function automatic rom_entry_t pattern_rom(input logic [2:0] pat);
    rom_entry_t e;
    case (pat)
      3'd0:    e = '{4'd2, 8'h01, 8'h03};
      3'd1:    e = '{4'd2, 8'h01, 8'h00};
      3'd2:    e = '{4'd2, 8'h01, 8'h01};
      3'd3:    e = '{4'd2, 8'h01, 8'h02};
      3'd4:    e = '{4'd6, 8'h15, 8'h10};
      3'd5:    e = '{4'd8, 8'h55, 8'h40};
      3'd6:    e = '{4'd4, 8'h05, 8'h08};
      3'd7:    e = '{4'd6, 8'h15, 8'h20};
      default: e = '{4'd2, 8'h01, 8'h03};
    endcase
    return e;
  endfunction

endpackage

// ----- rtl/lbps_in_stage.sv -----
`timescale 1ns / 1ps

module lbps_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  lbps_pkg::req_t req_i,
  input  logic          move_i,
  output logic          valid_o,
  output lbps_pkg::req_t req_o
);

  logic           valid_q;
  lbps_pkg::req_t req_q;

  // hold while the result stage cannot take the request
  assign in_stall_o = valid_q & ~move_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      req_q <= req_i;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

// ----- rtl/lbps_seq_core.sv -----
`timescale 1ns / 1ps

module lbps_seq_core #(
  parameter int unsigned SPAN_BITS = lbps_pkg::SpanBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  lbps_pkg::req_t req_i,
  input  lbps_pkg::cfg_t cfg_i,
  output lbps_pkg::res_t res_o
);

  logic [3:0]           pat_q, pat_d;
  logic [2:0]           step_q, step_d;
  logic [SPAN_BITS-1:0] span_q, span_d;
  logic [SPAN_BITS:0]   elapsed_q, elapsed_d;
  logic                 lit_q, lit_d;

  logic                 running;
  logic [SPAN_BITS:0]   elapsed_inc;
  logic [3:0]           next_step;
  logic                 load;
  logic [2:0]           load_pat;
  logic [2:0]           load_step;
  lbps_pkg::rom_entry_t entry;
  lbps_pkg::rom_entry_t cur_entry;
  logic                 run_d;

  assign running     = (pat_q < lbps_pkg::NO_PATTERN);
  assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + 1'b1;
  assign cur_entry   = lbps_pkg::pattern_rom(pat_q[2:0]);

  always_comb begin
    next_step = {1'b0, step_q} + 4'd1;
    if (next_step >= cur_entry.length) begin
      next_step = 4'd0;
    end
  end

  always_comb begin
    pat_d     = pat_q;
    step_d    = step_q;
    span_d    = span_q;
    elapsed_d = elapsed_q;
    lit_d     = lit_q;
    load      = 1'b0;
    load_pat  = pat_q[2:0];
    load_step = next_step[2:0];
    case (req_i.command)
      lbps_pkg::CMD_TICK: begin
        if (running) begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc > {1'b0, span_q}) begin
            load = 1'b1;
          end
        end
      end
      lbps_pkg::CMD_START: begin
        if (req_i.pattern_select < lbps_pkg::NO_PATTERN) begin
          pat_d     = req_i.pattern_select;
          load      = 1'b1;
          load_pat  = req_i.pattern_select[2:0];
          load_step = 3'd0;
        end else if (req_i.pattern_select == lbps_pkg::NO_PATTERN) begin
          pat_d = lbps_pkg::NO_PATTERN;
          lit_d = 1'b0;
        end
      end
      lbps_pkg::CMD_STEADY_ON: begin
        pat_d = lbps_pkg::NO_PATTERN;
        lit_d = 1'b1;
      end
      default: begin
        pat_d = lbps_pkg::NO_PATTERN;
        lit_d = 1'b0;
      end
    endcase
    entry = lbps_pkg::pattern_rom(load_pat);
    if (load) begin
      step_d    = load_step;
      lit_d     = entry.lit_bits[load_step];
      span_d    = entry.long_bits[load_step] ? SPAN_BITS'(cfg_i.long_span)
                                             : SPAN_BITS'(cfg_i.short_span);
      elapsed_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q     <= lbps_pkg::NO_PATTERN;
      step_q    <= '0;
      span_q    <= '0;
      elapsed_q <= '0;
      lit_q     <= 1'b0;
    end else if (en_i) begin
      pat_q     <= pat_d;
      step_q    <= step_d;
      span_q    <= span_d;
      elapsed_q <= elapsed_d;
      lit_q     <= lit_d;
    end
  end

  assign run_d                 = (pat_d < lbps_pkg::NO_PATTERN);
  assign res_o.pin_level       = lit_d ~^ cfg_i.active_level;
  assign res_o.led_lit         = lit_d;
  assign res_o.pattern_running = run_d;
  assign res_o.step_index      = run_d ? step_d : 3'd0;

endmodule

// ----- rtl/lbps_out_stage.sv -----
`timescale 1ns / 1ps

module lbps_out_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  lbps_pkg::res_t res_i,
  output logic           move_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output lbps_pkg::res_t res_o
);

  logic           valid_q;
  lbps_pkg::res_t res_q;

  assign move_o = ~valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (move_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move_o && valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ----- rtl/led_blink_pattern_sequencer_top.sv -----
`timescale 1ns / 1ps
// path: an accepted request waits in the input register, its result in the result register
// throughput: one request per cycle while the result side does not stall, set by the single
// state update between the input register and the result register
// reset: asynchronous active low; no pattern running, led dark, registers at
// active high, short span 200 and long span 800

module led_blink_pattern_sequencer_top #(
  parameter int unsigned SPAN_BITS = lbps_pkg::SpanBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    command_i,
  input  logic [3:0]                    pattern_select_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          pin_level_o,
  output logic                          led_lit_o,
  output logic                          pattern_running_o,
  output logic [2:0]                    step_index_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lbps_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lbps_pkg::CfgDataW-1:0] cfg_data_i
);

  lbps_pkg::cfg_t cfg_q;
  lbps_pkg::req_t in_req;
  lbps_pkg::req_t stage_req;
  lbps_pkg::res_t core_res;
  lbps_pkg::res_t out_res;
  logic           stage_valid;
  logic           move;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_level <= 1'b1;
      cfg_q.short_span   <= lbps_pkg::SHORT_SPAN_RST;
      cfg_q.long_span    <= lbps_pkg::LONG_SPAN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        lbps_pkg::CFG_ACTIVE_LEVEL: cfg_q.active_level <= cfg_data_i[0];
        lbps_pkg::CFG_SHORT_SPAN:   cfg_q.short_span   <= cfg_data_i;
        lbps_pkg::CFG_LONG_SPAN:    cfg_q.long_span    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign in_req.command        = command_i;
  assign in_req.pattern_select = pattern_select_i;

  lbps_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_i      (in_req),
    .move_i     (move),
    .valid_o    (stage_valid),
    .req_o      (stage_req)
  );

  lbps_seq_core #(
    .SPAN_BITS (SPAN_BITS)
  ) u_seq_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (stage_valid & move),
    .req_i  (stage_req),
    .cfg_i  (cfg_q),
    .res_o  (core_res)
  );

  lbps_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (stage_valid),
    .res_i       (core_res),
    .move_o      (move),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign pin_level_o       = out_res.pin_level;
  assign led_lit_o         = out_res.led_lit;
  assign pattern_running_o = out_res.pattern_running;
  assign step_index_o      = out_res.step_index;

endmodule

// ----- rtl/lbps_checker.sv -----
`timescale 1ns / 1ps

module lbps_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       pin_level_o,
  input logic       led_lit_o,
  input logic       pattern_running_o,
  input logic [2:0] step_index_o
);

  // a stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pin_level_o) &&
      $stable(led_lit_o) && $stable(pattern_running_o) && $stable(step_index_o))
    else $error("stalled result changed");

  // step index reads zero when no pattern runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pattern_running_o |-> step_index_o == 3'd0)
    else $error("step index nonzero while idle");

  // with the result register empty the input side never stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result register");

  // input stall only follows a stalled full result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

endmodule

bind led_blink_pattern_sequencer_top lbps_checker u_lbps_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .pin_level_o       (pin_level_o),
  .led_lit_o         (led_lit_o),
  .pattern_running_o (pattern_running_o),
  .step_index_o      (step_index_o)
);

// ----- dv/led_blink_pattern_sequencer_top_tb.sv -----
`timescale 1ns / 1ps

class led_blink_scoreboard;
  localparam int SpanW = lbps_pkg::SpanBitsDef;

  bit [7:0] lit_mask[8];
  bit [7:0] long_mask[8];
  int unsigned seq_len[8];

  logic                          active_lvl;
  logic [lbps_pkg::CfgDataW-1:0] short_span;
  logic [lbps_pkg::CfgDataW-1:0] long_span;

  logic [3:0]       cur_pattern;
  logic [2:0]       cur_step;
  logic [SpanW-1:0] cur_span;
  logic [SpanW:0]   ticks_seen;
  logic             lit;

  lbps_pkg::res_t expected_leds[$];
  int             failures;

  function new();
    lit_mask  = '{8'h01, 8'h01, 8'h01, 8'h01, 8'h15, 8'h55, 8'h05, 8'h15};
    long_mask = '{8'h03, 8'h00, 8'h01, 8'h02, 8'h10, 8'h40, 8'h08, 8'h20};
    seq_len   = '{2, 2, 2, 2, 6, 8, 4, 6};
    active_lvl  = 1'b1;
    short_span  = lbps_pkg::SHORT_SPAN_RST;
    long_span   = lbps_pkg::LONG_SPAN_RST;
    cur_pattern = lbps_pkg::NO_PATTERN;
    cur_step    = '0;
    cur_span    = '0;
    ticks_seen  = '0;
    lit         = 1'b0;
    failures    = 0;
  endfunction

  function void set_register(logic [lbps_pkg::CfgIdxW-1:0] idx,
                             logic [lbps_pkg::CfgDataW-1:0] data);
    case (idx)
      lbps_pkg::CFG_ACTIVE_LEVEL: active_lvl = data[0];
      lbps_pkg::CFG_SHORT_SPAN:   short_span = data;
      lbps_pkg::CFG_LONG_SPAN:    long_span = data;
      default: ;
    endcase
  endfunction

  function void enter_step(logic [2:0] pat, logic [2:0] step);
    cur_step   = step;
    lit        = lit_mask[pat][step];
    cur_span   = long_mask[pat][step] ? long_span[SpanW-1:0] : short_span[SpanW-1:0];
    ticks_seen = '0;
  endfunction

  function lbps_pkg::res_t predict_led(logic [1:0] cmd, logic [3:0] sel);
    int unsigned nxt;
    lbps_pkg::res_t r;
    case (cmd)
      lbps_pkg::CMD_TICK: begin
        if (cur_pattern < lbps_pkg::NO_PATTERN) begin
          if (ticks_seen != '1) ticks_seen = ticks_seen + 1'b1;
          if (ticks_seen > {1'b0, cur_span}) begin
            nxt = cur_step + 1;
            if (nxt >= seq_len[cur_pattern[2:0]]) nxt = 0;
            enter_step(cur_pattern[2:0], nxt[2:0]);
          end
        end
      end
      lbps_pkg::CMD_START: begin
        if (sel < lbps_pkg::NO_PATTERN) begin
          cur_pattern = sel;
          enter_step(sel[2:0], 3'd0);
        end else if (sel == lbps_pkg::NO_PATTERN) begin
          cur_pattern = lbps_pkg::NO_PATTERN;
          lit = 1'b0;
        end
      end
      lbps_pkg::CMD_STEADY_ON: begin
        cur_pattern = lbps_pkg::NO_PATTERN;
        lit = 1'b1;
      end
      default: begin
        cur_pattern = lbps_pkg::NO_PATTERN;
        lit = 1'b0;
      end
    endcase
    r.pin_level       = lit ? active_lvl : ~active_lvl;
    r.led_lit         = lit;
    r.pattern_running = cur_pattern < lbps_pkg::NO_PATTERN;
    r.step_index      = (cur_pattern < lbps_pkg::NO_PATTERN) ? cur_step : 3'd0;
    return r;
  endfunction

  function void note_request(logic [1:0] cmd, logic [3:0] sel);
    expected_leds.push_back(predict_led(cmd, sel));
  endfunction

  function void check_result(lbps_pkg::res_t got);
    lbps_pkg::res_t want;
    if (expected_leds.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %b", $time, got);
      failures++;
      return;
    end
    want = expected_leds.pop_front();
    if (got.pin_level !== want.pin_level) begin
      $display("%0t: pin_level expected %0b actual %0b", $time, want.pin_level, got.pin_level);
      failures++;
    end
    if (got.led_lit !== want.led_lit) begin
      $display("%0t: led_lit expected %0b actual %0b", $time, want.led_lit, got.led_lit);
      failures++;
    end
    if (got.pattern_running !== want.pattern_running) begin
      $display("%0t: pattern_running expected %0b actual %0b", $time,
               want.pattern_running, got.pattern_running);
      failures++;
    end
    if (got.step_index !== want.step_index) begin
      $display("%0t: step_index expected %0d actual %0d", $time,
               want.step_index, got.step_index);
      failures++;
    end
  endfunction
endclass

module led_blink_pattern_sequencer_top_tb;

  localparam int CycleLimit = 600000;

  logic                          clk;
  logic                          rst_ni;
  logic                          in_valid;
  logic                          in_stall;
  logic [1:0]                    command;
  logic [3:0]                    psel;
  logic                          out_valid;
  logic                          out_stall;
  logic                          pin_level;
  logic                          led_lit;
  logic                          pattern_running;
  logic [2:0]                    step_index;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [lbps_pkg::CfgIdxW-1:0]  cfg_index;
  logic [lbps_pkg::CfgDataW-1:0] cfg_data;

  bit send_quiet;
  bit recv_quiet;
  int rx_gap;
  int cycle_count;

  led_blink_scoreboard sb;

  led_blink_pattern_sequencer_top u_dut (
    .clk_i             (clk),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .command_i         (command),
    .pattern_select_i  (psel),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .pin_level_o       (pin_level),
    .led_lit_o         (led_lit),
    .pattern_running_o (pattern_running),
    .step_index_o      (step_index),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // request and result monitors
  always @(posedge clk) begin
    if (rst_ni && in_valid && !in_stall) sb.note_request(command, psel);
  end

  always @(posedge clk) begin
    if (rst_ni && out_valid && !out_stall)
      sb.check_result('{pin_level, led_lit, pattern_running, step_index});
  end

  function automatic int draw_gap(ref bit quiet);
    if ($urandom_range(0, 23) == 0) quiet = !quiet;
    return quiet ? 0 : $urandom_range(0, 11);
  endfunction

  task automatic send_request(input logic [1:0] cmd, input logic [3:0] sel);
    int gap;
    gap = draw_gap(send_quiet);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    command  = cmd;
    psel     = sel;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (sb.expected_leds.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(input logic [lbps_pkg::CfgIdxW-1:0] idx,
                                input logic [lbps_pkg::CfgDataW-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_config(input logic act, input logic [lbps_pkg::CfgDataW-1:0] short_ms,
                            input logic [lbps_pkg::CfgDataW-1:0] long_ms);
    drain();
    write_register(lbps_pkg::CFG_ACTIVE_LEVEL, {{(lbps_pkg::CfgDataW-1){1'b0}}, act});
    write_register(lbps_pkg::CFG_SHORT_SPAN, short_ms);
    write_register(lbps_pkg::CFG_LONG_SPAN, long_ms);
  endtask

  task automatic run_random(input int count);
    int r;
    logic [3:0] sel;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      sel = 4'($urandom_range(0, 15));
      if (r < 68) begin
        send_request(lbps_pkg::CMD_TICK, sel);
      end else if (r < 86) begin
        sel = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(8, 15))
                                          : 4'($urandom_range(0, 7));
        send_request(lbps_pkg::CMD_START, sel);
      end else if (r < 93) begin
        send_request(lbps_pkg::CMD_STEADY_ON, sel);
      end else begin
        send_request(lbps_pkg::CMD_STEADY_OFF, sel);
      end
    end
  endtask

  // result side stall
  initial begin
    out_stall = 1'b0;
    wait (rst_ni);
    @(negedge clk);
    forever begin
      rx_gap = draw_gap(recv_quiet);
      if (rx_gap != 0) begin
        out_stall = 1'b1;
        repeat (rx_gap) @(negedge clk);
      end
      out_stall = 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    sb          = new();
    cycle_count = 0;
    rst_ni      = 1'b0;
    in_valid    = 1'b0;
    command     = lbps_pkg::CMD_TICK;
    psel        = '0;
    cfg_valid   = 1'b0;
    cfg_index   = lbps_pkg::CFG_ACTIVE_LEVEL;
    cfg_data    = '0;
    send_quiet  = 1'b0;
    recv_quiet  = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    // directed, reset settings
    send_request(lbps_pkg::CMD_TICK, 4'd0);
    send_request(lbps_pkg::CMD_TICK, 4'd15);
    send_request(lbps_pkg::CMD_START, 4'd9);
    send_request(lbps_pkg::CMD_START, 4'd15);
    send_request(lbps_pkg::CMD_START, 4'd8);
    send_request(lbps_pkg::CMD_STEADY_ON, 4'd5);
    send_request(lbps_pkg::CMD_STEADY_OFF, 4'd10);
    send_request(lbps_pkg::CMD_STEADY_ON, 4'd0);
    for (int p = 0; p < 8; p++) begin
      send_request(lbps_pkg::CMD_START, p[3:0]);
      send_request(lbps_pkg::CMD_TICK, 4'd15 - p[3:0]);
    end
    send_request(lbps_pkg::CMD_START, 4'd8);
    send_request(lbps_pkg::CMD_STEADY_OFF, 4'd15);
    send_request(lbps_pkg::CMD_START, 4'd12);

    set_config(1'b0, 10'd1, 10'd2);
    run_random(220);
    // zero spans end a step on its first tick
    set_config(1'b1, 10'd0, 10'd0);
    run_random(120);
    set_config(1'b0, 10'd5, 10'd13);
    run_random(250);

    // widest short span holds its step
    set_config(1'b1, 10'd1023, 10'd1);
    send_request(lbps_pkg::CMD_START, 4'd3);
    for (int i = 0; i < 40; i++) send_request(lbps_pkg::CMD_TICK, 4'($urandom_range(0, 15)));

    set_config(1'b0, 10'd1, 10'd1023);
    run_random(150);
    set_config(1'b1, 10'd3, 10'd9);
    run_random(110);

    drain();
    repeat (8) @(negedge clk);
    if (sb.failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
